### rtl/core/lra_pkg.sv
// ----------------------------------------------------------------------------
// lra_pkg
// Shared widths, defaults and status codes of the level request aggregator.
// ----------------------------------------------------------------------------
package lra_pkg;

  localparam int ID_W        = 8;
  localparam int LEVEL_W     = 32;
  localparam int SUM_W       = 36;
  localparam int COUNT_W     = 5;
  localparam int STATUS_W    = 2;

  localparam int IN_TDATA_W  = 40;
  localparam int OUT_FIELD_W = SUM_W + LEVEL_W + 1 + COUNT_W;
  localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;
  localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_FIELD_W;

  localparam int DEF_MAX_REQUESTERS = 16;
  localparam int DEF_LEVEL_BITS     = 32;
  localparam int DEF_ID_BITS        = 8;
  localparam int QUEUE_DEPTH        = 2;

  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd2;

endpackage

### rtl/core/lra_front.sv
// ----------------------------------------------------------------------------
// lra_front
// Input stage: accepts requests, trims id and level to the configured widths
// and hands packed items to the queue.
// ----------------------------------------------------------------------------
module lra_front import lra_pkg::*; #(
  parameter int OWN_W = DEF_ID_BITS,
  parameter int LVL_W = DEF_LEVEL_BITS
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_tvalid,
  output logic                     s_tready,
  input  logic [IN_TDATA_W-1:0]    s_tdata,   // requester_id [7:0], level [39:8]
  input  logic                     s_tuser,   // operation
  output logic                     q_valid,
  input  logic                     q_ready,
  output logic [OWN_W+LVL_W:0]     q_data
);

  logic                 hold_vld;
  logic [OWN_W+LVL_W:0] hold_data;

  assign s_tready = !hold_vld || q_ready;
  assign q_valid  = hold_vld;
  assign q_data   = hold_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_vld <= 1'b0;
    end else if (s_tready) begin
      hold_vld <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      hold_data <= {s_tuser, s_tdata[OWN_W-1:0], s_tdata[ID_W +: LVL_W]};
    end
  end

endmodule

### rtl/core/lra_queue.sv
// ----------------------------------------------------------------------------
// lra_queue
// Small FIFO between the input stage and the table engine.
// ----------------------------------------------------------------------------
module lra_queue import lra_pkg::*; #(
  parameter int WIDTH = 1,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [WIDTH-1:0] in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [WIDTH-1:0] out_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wptr;
  logic [PTR_W-1:0] rptr;
  logic [CNT_W-1:0] fill;
  logic             push;
  logic             pop;

  assign in_ready  = fill != CNT_W'(DEPTH);
  assign out_valid = fill != '0;
  assign out_data  = slots[rptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == PTR_W'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == PTR_W'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= in_data;
    end
  end

endmodule

### rtl/core/lra_engine.sv
// ----------------------------------------------------------------------------
// lra_engine
// Table engine: walks the requester table once per item to find the owner,
// the first free entry and the largest other level, then updates the table,
// sum, maximum and count and loads the result register.
// ----------------------------------------------------------------------------
module lra_engine import lra_pkg::*; #(
  parameter int MAX_REQUESTERS = DEF_MAX_REQUESTERS,
  parameter int OWN_W          = DEF_ID_BITS,
  parameter int LVL_W          = DEF_LEVEL_BITS
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     q_valid,
  output logic                     q_ready,
  input  logic [OWN_W+LVL_W:0]     q_data,
  output logic                     m_tvalid,
  input  logic                     m_tready,
  output logic [OUT_TDATA_W-1:0]   m_tdata,
  output logic [STATUS_W-1:0]      m_tuser
);

  localparam int IDX_W = $clog2(MAX_REQUESTERS);
  localparam int CNT_W = $clog2(MAX_REQUESTERS + 1);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SCAN   = 3'd1;
  localparam logic [2:0] ST_DRAIN  = 3'd2;
  localparam logic [2:0] ST_PREP   = 3'd3;
  localparam logic [2:0] ST_UPDATE = 3'd4;

  logic [2:0]                state;
  logic [IDX_W-1:0]          addr;

  logic [OWN_W-1:0]          own_mem [MAX_REQUESTERS];
  logic [LVL_W-1:0]          lvl_mem [MAX_REQUESTERS];
  logic [MAX_REQUESTERS-1:0] valid;

  logic                      cmp_en;
  logic [IDX_W-1:0]          cmp_idx;
  logic [OWN_W-1:0]          own_rd;
  logic [LVL_W-1:0]          lvl_rd;

  logic                      cur_rel;
  logic [OWN_W-1:0]          cur_id;
  logic [LVL_W-1:0]          cur_lvl;

  logic                      hit;
  logic [IDX_W-1:0]          hit_idx;
  logic [LVL_W-1:0]          hit_lvl;
  logic                      free_found;
  logic [IDX_W-1:0]          free_idx;
  logic [LVL_W-1:0]          max_excl;

  logic [SUM_W-1:0]          sum_base;
  logic [LVL_W-1:0]          cand_max;

  logic [SUM_W-1:0]          level_sum;
  logic [LVL_W-1:0]          level_max;
  logic [CNT_W-1:0]          active_count;

  logic                      out_vld;
  logic [SUM_W-1:0]          out_sum;
  logic [LVL_W-1:0]          out_max;
  logic                      out_changed;
  logic [CNT_W-1:0]          out_count;
  logic [STATUS_W-1:0]       out_status;

  logic                      upd_go;
  logic                      do_write;
  logic                      is_new;
  logic                      is_free;
  logic [IDX_W-1:0]          wr_idx;
  logic [SUM_W-1:0]          sum_next;
  logic [CNT_W-1:0]          count_next;
  logic [STATUS_W-1:0]       status_next;

  assign q_ready  = state == ST_IDLE;
  assign m_tvalid = out_vld;
  assign m_tdata  = {{OUT_PAD_W{1'b0}}, COUNT_W'(out_count), out_changed,
                     LEVEL_W'(out_max), out_sum};
  assign m_tuser  = out_status;

  always_comb begin
    upd_go      = (state == ST_UPDATE) && (!out_vld || m_tready);
    is_new      = !cur_rel && !hit && free_found;
    is_free     = cur_rel && hit;
    do_write    = !cur_rel && (hit || free_found);
    wr_idx      = hit ? hit_idx : free_idx;
    sum_next    = sum_base + (do_write ? SUM_W'(cur_lvl) : '0);
    count_next  = active_count;
    status_next = STATUS_OK;
    if (is_new) begin
      count_next = active_count + 1'b1;
    end else if (is_free) begin
      count_next = active_count - 1'b1;
    end
    if (cur_rel && !hit) begin
      status_next = STATUS_NOT_FOUND;
    end else if (!cur_rel && !hit && !free_found) begin
      status_next = STATUS_FULL;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      addr         <= '0;
      cmp_en       <= 1'b0;
      valid        <= '0;
      level_sum    <= '0;
      level_max    <= '0;
      active_count <= '0;
      out_vld      <= 1'b0;
    end else begin
      cmp_en <= state == ST_SCAN;
      if (upd_go) begin
        out_vld <= 1'b1;
      end else if (m_tready) begin
        out_vld <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          addr <= '0;
          if (q_valid) begin
            state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (addr == IDX_W'(MAX_REQUESTERS - 1)) begin
            state <= ST_DRAIN;
          end else begin
            addr <= addr + 1'b1;
          end
        end
        ST_DRAIN: begin
          state <= ST_PREP;
        end
        ST_PREP: begin
          state <= ST_UPDATE;
        end
        ST_UPDATE: begin
          if (upd_go) begin
            state        <= ST_IDLE;
            level_sum    <= sum_next;
            level_max    <= cand_max;
            active_count <= count_next;
            if (is_new) begin
              valid[free_idx] <= 1'b1;
            end else if (is_free) begin
              valid[hit_idx] <= 1'b0;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && q_valid) begin
      cur_rel    <= q_data[OWN_W+LVL_W];
      cur_id     <= q_data[LVL_W +: OWN_W];
      cur_lvl    <= q_data[LVL_W-1:0];
      hit        <= 1'b0;
      free_found <= 1'b0;
      max_excl   <= '0;
    end else if (cmp_en) begin
      if (valid[cmp_idx]) begin
        if (own_rd == cur_id) begin
          hit     <= 1'b1;
          hit_idx <= cmp_idx;
          hit_lvl <= lvl_rd;
        end else if (lvl_rd > max_excl) begin
          max_excl <= lvl_rd;
        end
      end else if (!free_found) begin
        free_found <= 1'b1;
        free_idx   <= cmp_idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_SCAN) begin
      own_rd  <= own_mem[addr];
      lvl_rd  <= lvl_mem[addr];
      cmp_idx <= addr;
    end
    if (upd_go && do_write) begin
      own_mem[wr_idx] <= cur_id;
      lvl_mem[wr_idx] <= cur_lvl;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_PREP) begin
      sum_base <= level_sum - (hit ? SUM_W'(hit_lvl) : '0);
      cand_max <= (do_write && cur_lvl > max_excl) ? cur_lvl : max_excl;
    end
    if (upd_go) begin
      out_sum     <= sum_next;
      out_max     <= cand_max;
      out_changed <= cand_max != level_max;
      out_count   <= count_next;
      out_status  <= status_next;
    end
  end

endmodule

### rtl/core/level_request_aggregator.sv
// ----------------------------------------------------------------------------
// level_request_aggregator
// Items are handled one at a time: the engine takes no new item until it has
// walked the requester table through its single read port, one entry per
// cycle, and loaded the result register.
// Reset: synchronous, clears all valid bits, sum, maximum, count and queue.
// ----------------------------------------------------------------------------
module level_request_aggregator import lra_pkg::*; #(
  parameter int MAX_REQUESTERS = DEF_MAX_REQUESTERS,
  parameter int LEVEL_BITS     = DEF_LEVEL_BITS,
  parameter int ID_BITS        = DEF_ID_BITS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,   // requester_id [7:0], level [39:8]
  input  logic                   s_tuser,   // operation
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // total_level [35:0], peak_level [67:36], max_changed [68],
  // user_count [73:69], zero [79:74]
  output logic [OUT_TDATA_W-1:0] m_tdata,
  output logic [STATUS_W-1:0]    m_tuser    // status
);

  localparam int OWN_W  = (ID_BITS < ID_W) ? ID_BITS : ID_W;
  localparam int LVL_W  = (LEVEL_BITS < LEVEL_W) ? LEVEL_BITS : LEVEL_W;
  localparam int ITEM_W = 1 + OWN_W + LVL_W;

  logic              f_valid;
  logic              f_ready;
  logic [ITEM_W-1:0] f_data;
  logic              q_valid;
  logic              q_ready;
  logic [ITEM_W-1:0] q_data;

  lra_front #(
    .OWN_W (OWN_W),
    .LVL_W (LVL_W)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_valid  (f_valid),
    .q_ready  (f_ready),
    .q_data   (f_data)
  );

  lra_queue #(
    .WIDTH (ITEM_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_data   (f_data),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_data  (q_data)
  );

  lra_engine #(
    .MAX_REQUESTERS (MAX_REQUESTERS),
    .OWN_W          (OWN_W),
    .LVL_W          (LVL_W)
  ) u_engine (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_data   (q_data),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule
